/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the interpolation table block.
// Depends on nothing; included by the top level, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// Next-cycle implication: when ante holds, cons must hold in the cycle after.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`endif

/* rtl/clit_pkg.sv */
// Package of the clamped linear interpolation table: widths, codes, types.
// Depends on nothing; used by clit_divider and the top level.
package clit_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 32;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);

	// Field widths.
	localparam int TERM_W   = 16;
	localparam int VALUE_W  = 32;
	localparam int POINTS_W = 6;
	localparam int SLOT_W   = 5;

	// Arithmetic widths: value difference times term offset, then the divide.
	localparam int DIFF_W      = VALUE_W + 1;
	localparam int DT_W        = TERM_W + 1;
	localparam int PROD_FULL_W = DIFF_W + DT_W;
	localparam int PROD_W      = VALUE_W + TERM_W;
	localparam int QUO_W       = VALUE_W + 1;
	localparam int DCNT_W      = $clog2(QUO_W + 1);

	// Configuration port.
	localparam int APB_DATA_W = 32;
	localparam int ADDR_W     = 3;
	localparam logic [ADDR_W-3:0] REG_POINTS_IN_USE = '0;
	localparam logic [POINTS_W-1:0] POINTS_RESET = POINTS_W'(2);

	// Item modes.
	localparam logic MODE_WRITE = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// One table point as held in the memory.
	typedef struct packed {
		logic [TERM_W-1:0]         term;
		logic signed [VALUE_W-1:0] value;
	} entry_t;

	// Query sequencer.
	typedef enum logic [2:0] {
		S_IDLE,
		S_FIRST,
		S_LAST,
		S_SCAN,
		S_MUL,
		S_START,
		S_DIV,
		S_RES
	} state_t;

endpackage

/* rtl/clit_divider.sv */
// Bit-serial restoring divider: unsigned product magnitude by a term span.
// Depends on clit_pkg for widths; one quotient bit per cycle.
module clit_divider (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [clit_pkg::PROD_W-1:0]        dividend,
	input  logic [clit_pkg::TERM_W-1:0]        divisor,
	output logic                               done,
	output logic [clit_pkg::QUO_W-1:0]         quotient
);

	logic                              busy_q;
	logic                              done_q;
	logic [clit_pkg::DCNT_W-1:0]       count_q;
	logic [clit_pkg::TERM_W-1:0]       rem_q;
	logic [clit_pkg::QUO_W-1:0]        sh_q;
	logic [clit_pkg::TERM_W-1:0]       den_q;
	logic [clit_pkg::TERM_W:0]         trial;
	logic                              ge;
	logic [clit_pkg::TERM_W:0]         diff;
	logic [clit_pkg::TERM_W-1:0]       rem_d;

	// One trial subtraction: bring down the next dividend bit and compare.
	always_comb begin
		trial = {rem_q, sh_q[clit_pkg::QUO_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
		rem_d = ge ? diff[clit_pkg::TERM_W-1:0] : trial[clit_pkg::TERM_W-1:0];
	end

	// Control: the quotient is known to fit QUO_W bits, so the top dividend
	// bits load straight into the remainder and only QUO_W steps remain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q  <= 1'b1;
				count_q <= clit_pkg::DCNT_W'(clit_pkg::QUO_W);
			end else if (busy_q) begin
				count_q <= count_q - 1'b1;
				if (count_q == clit_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the shift register feeds dividend bits out and quotient bits in.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= clit_pkg::TERM_W'(dividend[clit_pkg::PROD_W-1:clit_pkg::QUO_W]);
			sh_q  <= dividend[clit_pkg::QUO_W-1:0];
			den_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_d;
			sh_q  <= {sh_q[clit_pkg::QUO_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

/* rtl/clamped_linear_interpolation_table.sv */
// Clamped linear interpolation table. A write word stores one grid point
// (term, value) in a 32-entry memory and gives no result. A query word is
// checked against the first point, then against the last, and clamps to
// whichever it falls beyond; otherwise a linear search finds the upper
// bracketing point at position i (1 to points_in_use - 1) and the result is
// interpolated with a divide. The single memory read port is walked by the
// linear search one entry per cycle, and the bit-serial divider yields one of
// 33 quotient bits per cycle. The block takes no word while a query is in
// progress; the result waits in an output register, so write words are taken
// while it is pending. The table has no reset: entries must be written before
// queries read them.
module clamped_linear_interpolation_table (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// Input words.
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   mode,
	input  logic [clit_pkg::SLOT_W-1:0]            point_index,
	input  logic [clit_pkg::TERM_W-1:0]            point_term,
	input  logic signed [clit_pkg::VALUE_W-1:0]    point_value,
	input  logic [clit_pkg::TERM_W-1:0]            target_term,
	// Result words.
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [clit_pkg::VALUE_W-1:0]    interpolated_value,
	// Configuration port.
	input  logic                                   psel,
	input  logic                                   penable,
	input  logic                                   pwrite,
	input  logic [clit_pkg::ADDR_W-1:0]            paddr,
	input  logic [clit_pkg::APB_DATA_W-1:0]        pwdata,
	output logic [clit_pkg::APB_DATA_W-1:0]        prdata,
	output logic                                   pready
);

`include "assert_macros.svh"

	clit_pkg::state_t                     state_q, state_d;
	logic [clit_pkg::POINTS_W-1:0]        points_q;
	logic [clit_pkg::IDX_W-1:0]           last_idx;
	logic [clit_pkg::IDX_W-1:0]           idx_q;
	logic [clit_pkg::IDX_W-1:0]           rd_addr;
	clit_pkg::entry_t                     mem [clit_pkg::TABLE_DEPTH];
	clit_pkg::entry_t                     rdata_q;
	clit_pkg::entry_t                     lo_q, hi_q;
	logic [clit_pkg::TERM_W-1:0]          target_q;
	logic signed [clit_pkg::PROD_FULL_W-1:0] prod_d, prod_q;
	logic [clit_pkg::PROD_FULL_W-1:0]     prod_mag;
	logic [clit_pkg::TERM_W-1:0]          den_q;
	logic                                 neg_q;
	logic signed [clit_pkg::DIFF_W-1:0]   diff_v;
	logic [clit_pkg::TERM_W-1:0]          dt;
	logic signed [clit_pkg::DT_W-1:0]     dt_s;
	logic                                 div_done;
	logic [clit_pkg::QUO_W-1:0]           div_quo;
	logic signed [clit_pkg::QUO_W:0]      quo_s;
	logic signed [clit_pkg::QUO_W:0]      sum_s;
	logic signed [clit_pkg::VALUE_W-1:0]  res_q;
	logic signed [clit_pkg::VALUE_W-1:0]  res_d;
	logic                                 out_valid_q;
	logic signed [clit_pkg::VALUE_W-1:0]  out_value_q;
	logic                                 in_acc;
	logic                                 cfg_wr;
	logic                                 tbl_wr;
	logic                                 first_hit;
	logic                                 last_hit;
	logic                                 scan_stop;
	logic                                 out_load;
	logic                                 lo_load_first;
	logic                                 lo_load_scan;
	logic                                 res_load;
	logic                                 div_start;

	// Configuration register and read-back.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[clit_pkg::ADDR_W-1:2] == clit_pkg::REG_POINTS_IN_USE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= clit_pkg::POINTS_RESET;
		end else if (cfg_wr) begin
			points_q <= pwdata[clit_pkg::POINTS_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[clit_pkg::ADDR_W-1:2] == clit_pkg::REG_POINTS_IN_USE) begin
			prdata = clit_pkg::APB_DATA_W'(points_q);
		end
	end

	// Index of the last point in use, with zero taken as one point and
	// counts beyond the table clamped to its depth.
	always_comb begin
		if (points_q == '0) begin
			last_idx = '0;
		end else if (32'(points_q) > 32'(clit_pkg::TABLE_DEPTH)) begin
			last_idx = clit_pkg::IDX_W'(clit_pkg::TABLE_DEPTH - 1);
		end else begin
			last_idx = clit_pkg::IDX_W'(points_q - 1'b1);
		end
	end

	// Handshake on the input side.
	assign in_ready = (state_q == clit_pkg::S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign tbl_wr   = in_acc && (mode == clit_pkg::MODE_WRITE)
		&& (32'(point_index) < 32'(clit_pkg::TABLE_DEPTH));

	// Point memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (tbl_wr) begin
			mem[clit_pkg::IDX_W'(point_index)] <= '{term: point_term, value: point_value};
		end
		rdata_q <= mem[rd_addr];
	end

	// Decisions taken on the word just read.
	assign first_hit = target_q <= rdata_q.term;
	assign last_hit  = target_q >= rdata_q.term;
	assign scan_stop = (rdata_q.term >= target_q) || (idx_q == last_idx);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			clit_pkg::S_IDLE: begin
				if (in_acc && (mode == clit_pkg::MODE_QUERY)) begin
					state_d = clit_pkg::S_FIRST;
				end
			end
			clit_pkg::S_FIRST: begin
				state_d = first_hit ? clit_pkg::S_RES : clit_pkg::S_LAST;
			end
			clit_pkg::S_LAST: begin
				state_d = last_hit ? clit_pkg::S_RES : clit_pkg::S_SCAN;
			end
			clit_pkg::S_SCAN: begin
				if (scan_stop) begin
					state_d = clit_pkg::S_MUL;
				end
			end
			clit_pkg::S_MUL: begin
				state_d = clit_pkg::S_START;
			end
			clit_pkg::S_START: begin
				state_d = clit_pkg::S_DIV;
			end
			clit_pkg::S_DIV: begin
				if (div_done) begin
					state_d = clit_pkg::S_RES;
				end
			end
			clit_pkg::S_RES: begin
				if (out_load) begin
					state_d = clit_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = clit_pkg::S_IDLE;
			end
		endcase
	end

	// Sequencer outputs: read address and load strobes.
	always_comb begin
		rd_addr       = '0;
		lo_load_first = 1'b0;
		lo_load_scan  = 1'b0;
		res_load      = 1'b0;
		res_d         = rdata_q.value;
		div_start     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			clit_pkg::S_IDLE: begin
				rd_addr = '0;
			end
			clit_pkg::S_FIRST: begin
				rd_addr       = last_idx;
				lo_load_first = 1'b1;
				res_load      = first_hit;
			end
			clit_pkg::S_LAST: begin
				rd_addr  = clit_pkg::IDX_W'(1);
				res_load = last_hit;
			end
			clit_pkg::S_SCAN: begin
				rd_addr      = idx_q + 1'b1;
				lo_load_scan = !scan_stop;
			end
			clit_pkg::S_START: begin
				div_start = 1'b1;
			end
			clit_pkg::S_DIV: begin
				res_load = div_done;
				res_d    = sum_s[clit_pkg::VALUE_W-1:0];
			end
			clit_pkg::S_RES: begin
				out_load = !out_valid_q || out_ready;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clit_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Bracketing points and search position.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			target_q <= target_term;
		end
		if (lo_load_first || lo_load_scan) begin
			lo_q <= rdata_q;
		end
		if (state_q == clit_pkg::S_LAST) begin
			idx_q <= clit_pkg::IDX_W'(1);
		end else if (lo_load_scan) begin
			idx_q <= idx_q + 1'b1;
		end
		if ((state_q == clit_pkg::S_SCAN) && scan_stop) begin
			hi_q <= rdata_q;
		end
	end

	// Exact product of the value step and the term offset.
	always_comb begin
		diff_v = $signed({hi_q.value[clit_pkg::VALUE_W-1], hi_q.value})
			- $signed({lo_q.value[clit_pkg::VALUE_W-1], lo_q.value});
		dt     = target_q - lo_q.term;
		dt_s   = $signed({1'b0, dt});
		prod_d = diff_v * dt_s;
	end

	always_ff @(posedge clk) begin
		if (state_q == clit_pkg::S_MUL) begin
			prod_q <= prod_d;
			den_q  <= hi_q.term - lo_q.term;
		end
		if (div_start) begin
			neg_q <= prod_q[clit_pkg::PROD_FULL_W-1];
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// Magnitude into the divider; the sign goes back on the quotient.
	assign prod_mag = prod_q[clit_pkg::PROD_FULL_W-1] ? -prod_q : prod_q;

	clit_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_mag[clit_pkg::PROD_W-1:0]),
		.divisor  (den_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Truncated quotient added to the lower value.
	always_comb begin
		quo_s = neg_q ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
		sum_s = $signed({{2{lo_q.value[clit_pkg::VALUE_W-1]}}, lo_q.value}) + quo_s;
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_value_q <= res_q;
		end
	end

	assign out_valid          = out_valid_q;
	assign interpolated_value = out_value_q;

	// The divider only finishes while the sequencer waits for it.
	`ASSERT_IMPL(a_div_done_in_div, clk, arst_n, div_done, state_q == clit_pkg::S_DIV)
	// The search never runs past the last point in use nor reads the first.
	`ASSERT_IMPL(a_scan_range, clk, arst_n, state_q == clit_pkg::S_SCAN, (idx_q != '0) && (idx_q <= last_idx))
	// A query word always starts with the check against the first point.
	`ASSERT_NEXT(a_query_start, clk, arst_n, in_acc && (mode == clit_pkg::MODE_QUERY), state_q == clit_pkg::S_FIRST)

endmodule
